// ===== hdl/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u8_pkg: shared types and helpers of the UTF-16 to UTF-8 encoder
// Transaction structs, the front-to-back command and the byte formatter.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // Surrogate ranges and the supplementary plane base
    localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;
    localparam logic [15:0] ONE_BYTE_MAX    = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX    = 16'h07FF;

    // Sequence length codes (number of bytes minus one)
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } t_out;

    // Command from the front to the back: an optional held surrogate,
    // then an optional code point, for one input item
    typedef struct packed {
        logic        has_pre;
        logic [9:0]  pre_bits;
        logic        has_main;
        logic [20:0] main_cp;
        logic [1:0]  main_len;
        logic        eos;
    } t_cmd;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Byte idx of the UTF-8 sequence of cp with length code len
    function automatic logic [7:0] enc_byte(input logic [20:0] cp,
                                            input logic [1:0]  len,
                                            input logic [1:0]  idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: begin
                case (idx)
                    2'd0:    b = {3'b110, cp[10:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// u2u8_front: input side of the encoder
// Accepts code units, tracks a held high surrogate and issues commands.
// ----------------------------------------------------------------------------
module u2u8_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  u2u8_pkg::t_in       i_in_data,
    input  u2u8_pkg::t_q_status i_q_status,
    output logic                o_push,
    output u2u8_pkg::t_cmd      o_cmd
);
    import u2u8_pkg::*;

    logic       r_pending;
    logic [9:0] r_held;
    logic       n_pending;
    logic [9:0] n_held;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        pair;
    logic        hold;
    logic [1:0]  unit_len;
    t_cmd        cmd;

    // Classify the incoming unit
    always_comb begin
        is_high = i_in_data.code_unit inside {[SURR_HIGH_FIRST:SURR_HIGH_LAST]};
        is_low  = i_in_data.code_unit inside {[SURR_LOW_FIRST:SURR_LOW_LAST]};
        if (i_in_data.code_unit <= ONE_BYTE_MAX) begin
            unit_len = LEN_1;
        end else if (i_in_data.code_unit <= TWO_BYTE_MAX) begin
            unit_len = LEN_2;
        end else begin
            unit_len = LEN_3;
        end
    end

    // Build the command for this unit
    always_comb begin
        pair = r_pending && is_low;
        hold = !pair && is_high && !i_in_data.end_of_string;
        cmd.has_pre  = r_pending && !is_low;
        cmd.pre_bits = r_held;
        cmd.has_main = !hold;
        cmd.main_cp  = pair ? (SUPP_BASE + {1'b0, r_held, i_in_data.code_unit[9:0]})
                            : {5'd0, i_in_data.code_unit};
        cmd.main_len = pair ? LEN_4 : unit_len;
        cmd.eos      = i_in_data.end_of_string;
    end

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept && (cmd.has_pre || cmd.has_main);
    assign o_cmd      = cmd;

    // Update the held surrogate on each accepted unit
    always_comb begin
        n_pending = r_pending;
        n_held    = r_held;
        if (accept) begin
            n_pending = hold;
            if (hold) begin
                n_held = i_in_data.code_unit[9:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= 10'd0;
        end else begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

// ===== hdl/u2u8_queue.sv =====
// ----------------------------------------------------------------------------
// u2u8_queue: two-entry command queue
// Decouples the front from the byte serialiser.
// ----------------------------------------------------------------------------
module u2u8_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u2u8_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output u2u8_pkg::t_cmd      o_head,
    output u2u8_pkg::t_q_status o_status
);
    import u2u8_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    // Advance pointers and occupancy
    always_comb begin
        n_wr  = i_push ? !r_wr : r_wr;
        n_rd  = i_pop  ? !r_rd : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// u2u8_back: byte serialiser
// Turns each command into UTF-8 bytes, one per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module u2u8_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  u2u8_pkg::t_cmd i_head,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output u2u8_pkg::t_out o_out_data
);
    import u2u8_pkg::*;

    t_cmd       r_cmd;
    logic       r_busy;
    logic       r_pre;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out       r_out;

    t_cmd       n_cmd;
    logic       n_busy;
    logic       n_pre;
    logic [1:0] n_idx;
    logic       n_out_valid;
    t_out       n_out;

    logic [20:0] sel_cp;
    logic [1:0]  sel_len;
    logic        phase_end;
    logic        last_byte;
    logic        adv;
    logic        emit;
    logic        pop;

    // Select the sequence being sent
    always_comb begin
        sel_cp    = r_pre ? {5'd0, SURR_HIGH_FIRST[15:10], r_cmd.pre_bits} : r_cmd.main_cp;
        sel_len   = r_pre ? LEN_3 : r_cmd.main_len;
        phase_end = (r_idx == sel_len);
        last_byte = phase_end && !(r_pre && r_cmd.has_main);
        adv       = !r_out_valid || !i_out_stall;
        emit      = r_busy && adv;
        pop       = !i_q_empty && (!r_busy || (emit && last_byte));
    end

    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Step through the bytes and load the next command
    always_comb begin
        n_cmd       = r_cmd;
        n_busy      = r_busy;
        n_pre       = r_pre;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out.out_byte    = enc_byte(sel_cp, sel_len, r_idx);
            n_out.run_last    = last_byte;
            n_out.string_done = last_byte && r_cmd.eos;
            n_out_valid       = 1'b1;
            if (!last_byte) begin
                if (phase_end) begin
                    n_pre = 1'b0;
                    n_idx = 2'd0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end else begin
                n_busy = 1'b0;
            end
        end else if (adv) begin
            n_out_valid = 1'b0;
        end
        if (pop) begin
            n_cmd  = i_head;
            n_busy = 1'b1;
            n_pre  = i_head.has_pre;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pre       <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pre       <= n_pre;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

endmodule

// ===== hdl/utf16_to_utf8_encoder_top.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_top: streaming UTF-16 to UTF-8 encoder
// Front classifier, two-entry command queue and byte serialiser.
// ----------------------------------------------------------------------------
// One UTF-16 code unit enters per transaction and leaves as UTF-8 bytes, one
// byte per output transaction, with run_last on the final byte of that unit
// and string_done on the final byte of the string. A non-final high
// surrogate is held and produces nothing until the next unit; a following
// low surrogate completes a four-byte sequence, anything else first flushes
// the held surrogate as three bytes. The output runs at one byte per cycle
// while it is not stalled. A unit produces 1 to 3 bytes if ordinary, 4 for
// a pair, up to 6 when a held surrogate is flushed, 0 for a held high
// surrogate. The byte serialiser sets the output rate; the input keeps
// accepting one unit per cycle while the two-entry command queue has room.
module utf16_to_utf8_encoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  u2u8_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output u2u8_pkg::t_out o_out_data
);
    import u2u8_pkg::*;

    t_q_status q_status;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      push;
    logic      pop;

    u2u8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    u2u8_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    u2u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_empty   (q_status.empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Never write into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_status.full))
        else $error("command pushed into full queue");

    // Never pop an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_status.empty))
        else $error("command popped from empty queue");

    // End of string only on the last byte of a run
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.string_done |-> o_out_data.run_last)
        else $error("string_done without run_last");

    // Output idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

// ===== tb/tb_utf16_to_utf8_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_encoder_top: self-checking bench of the UTF-16 encoder
// Drives UTF-16 code units with random idle gaps and output stalls, predicts
// the UTF-8 byte stream with its own surrogate tracker and checks every byte.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_encoder_top;

    import u2u8_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 30;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;

    // Predictor state: the held high surrogate
    logic       pend_high = 1'b0;
    logic [9:0] pend_bits = 10'd0;

    logic [7:0] unit_bytes[$];
    t_out       utf8_expected[$];
    t_out       want;

    int mismatches  = 0;
    int units_sent  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit idle_en     = 1'b0;
    bit stall_en    = 1'b0;

    utf16_to_utf8_encoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit enable);
        int r;
        if (!enable) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Append the UTF-8 form of one code point to the staging bytes
    function automatic void append_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            unit_bytes.push_back({1'b0, cp[6:0]});
        end else if (cp < 21'h800) begin
            unit_bytes.push_back({3'b110, cp[10:6]});
            unit_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            unit_bytes.push_back({4'b1110, cp[15:12]});
            unit_bytes.push_back({2'b10, cp[11:6]});
            unit_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            unit_bytes.push_back({5'b11110, cp[20:18]});
            unit_bytes.push_back({2'b10, cp[17:12]});
            unit_bytes.push_back({2'b10, cp[11:6]});
            unit_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Work out the bytes that one accepted code unit releases
    function automatic void encode_unit(input t_in unit);
        logic [15:0] cu;
        logic        eos;
        logic        is_high;
        logic        is_low;
        logic        paired;
        t_out        res;
        cu      = unit.code_unit;
        eos     = unit.end_of_string;
        is_high = (cu >= 16'hD800) && (cu <= 16'hDBFF);
        is_low  = (cu >= 16'hDC00) && (cu <= 16'hDFFF);
        paired  = 1'b0;
        unit_bytes.delete();
        // Resolve a held high surrogate first
        if (pend_high) begin
            pend_high = 1'b0;
            if (is_low) begin
                append_cp(21'h10000 + {1'b0, pend_bits, cu[9:0]});
                paired = 1'b1;
            end else begin
                append_cp({5'b0, 6'b110110, pend_bits});
            end
        end
        if (!paired) begin
            if (is_high && !eos) begin
                pend_high = 1'b1;
                pend_bits = cu[9:0];
            end else begin
                append_cp({5'b0, cu});
            end
        end
        foreach (unit_bytes[i]) begin
            res.out_byte    = unit_bytes[i];
            res.run_last    = (i == unit_bytes.size() - 1);
            res.string_done = res.run_last && eos;
            utf8_expected.push_back(res);
        end
    endfunction

    // Predict on each input transaction, then check each output transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                encode_unit(in_data);
            end
            if (out_valid && !out_stall) begin
                if (utf8_expected.size() == 0) begin
                    $error("out_byte: expected nothing, actual %02h", out_data.out_byte);
                    mismatches++;
                end else begin
                    want = utf8_expected.pop_front();
                    if (out_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, out_data.out_byte);
                        mismatches++;
                    end
                    if (out_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, out_data.run_last);
                        mismatches++;
                    end
                    if (out_data.string_done !== want.string_done) begin
                        $error("string_done: expected %0b, actual %0b",
                               want.string_done, out_data.string_done);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stall the output in bursts while enabled
    always @(negedge clk) begin
        if (stall_left == 0 && stall_en && $urandom_range(0, 99) < 25) begin
            stall_left = 1 + pick_gap(1'b1);
        end
        if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
        end
    end

    // Send one code unit, holding it until the transaction completes
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        int gap;
        gap = pick_gap(idle_en);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid              = 1'b1;
        in_data.code_unit     = cu;
        in_data.end_of_string = eos;
        do @(posedge clk); while (in_stall);
        units_sent++;
    endtask

    // Hold the input off until every predicted byte has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (utf8_expected.size() != 0) @(posedge clk);
    endtask

    // One well-formed string of one to six characters, random content
    task automatic send_random_string();
        int          n_chars;
        int          kind;
        logic [15:0] cu;
        logic        fin;
        n_chars = $urandom_range(1, 6);
        for (int c = 0; c < n_chars; c++) begin
            fin  = (c == n_chars - 1);
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                send_unit(16'($urandom_range(0, 16'h007F)), fin);
            end else if (kind < 5) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07FF)), fin);
            end else if (kind < 7) begin
                if ($urandom_range(0, 1)) begin
                    cu = 16'($urandom_range(16'h0800, 16'hD7FF));
                end else begin
                    cu = 16'($urandom_range(16'hE000, 16'hFFFF));
                end
                send_unit(cu, fin);
            end else begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), fin);
            end
        end
    endtask

    // Noise: arbitrary units, stray surrogates and broken pairs
    task automatic send_noise_unit();
        case ($urandom_range(0, 2))
            0: send_unit(16'($urandom), 1'($urandom_range(0, 1)));
            1: send_unit(16'($urandom_range(16'hD800, 16'hDFFF)), 1'($urandom_range(0, 1)));
            default: begin
                send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                send_unit(16'($urandom_range(16'h0000, 16'hDBFF)), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    // Boundaries of the one, two and three byte forms
    task automatic test_encoding_lengths();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
    endtask

    // Lowest and highest pairs; the second closes the string on its low half
    task automatic test_surrogate_pairs();
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
    endtask

    // Stray low halves, flushed high halves and a high half at the end
    task automatic test_lone_surrogates();
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // held high followed by a plain character
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        // held high replaced by another high, which then pairs
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDC01, 1'b1);
        // high half as the final unit
        send_unit(16'hDABC, 1'b1);
        // held high flushed by a final high: six bytes in one go
        send_unit(16'hD900, 1'b0);
        send_unit(16'hDA00, 1'b1);
    endtask

    // Mostly well-formed strings with gaps on both sides, draining now and then
    task automatic test_random_traffic(input int n_units);
        int target;
        int next_pause;
        target     = units_sent + n_units;
        next_pause = units_sent + 40;
        while (units_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                send_random_string();
            end else begin
                send_noise_unit();
            end
            if (units_sent >= next_pause) begin
                wait_drained();
                next_pause += 40;
            end
        end
    endtask

    // Full-rate stretch: no input gaps and no output stalls
    task automatic test_back_to_back(input int n_units);
        int target;
        target   = units_sent + n_units;
        idle_en  = 1'b0;
        stall_en = 1'b0;
        while (units_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                send_random_string();
            end else begin
                send_noise_unit();
            end
        end
        idle_en  = 1'b1;
        stall_en = 1'b1;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        repeat (9) @(negedge clk);
        rst_n    = 1'b1;
        idle_en  = 1'b1;
        stall_en = 1'b1;

        test_encoding_lengths();
        test_surrogate_pairs();
        test_lone_surrogates();
        test_random_traffic(50);
        wait_drained();
        test_back_to_back(30);
        test_random_traffic(15);

        // Drain, then watch for stray bytes
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/u2u8_pkg.sv
hdl/u2u8_front.sv
hdl/u2u8_queue.sv
hdl/u2u8_back.sv
hdl/utf16_to_utf8_encoder_top.sv
tb/tb_utf16_to_utf8_encoder_top.sv
